### rtl/ssbm_pkg.sv
// Shared types and constants for the SPI slave byte memory.
package ssbm_pkg;

    localparam int          MEM_ADDR_W = 16;
    localparam logic [7:0]  READ_MODE  = 8'd2;
    localparam logic [7:0]  ERASED     = 8'hFF;

    // frame phase codes
    localparam logic [1:0]  PH_MODE    = 2'd0;
    localparam logic [1:0]  PH_ADDR_LO = 2'd1;
    localparam logic [1:0]  PH_ADDR_HI = 2'd2;
    localparam logic [1:0]  PH_FINAL   = 2'd3;

    // single-port memory request
    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [7:0]            wdata;
    } t_mem_req;

endpackage

### rtl/ssbm_mem.sv
// Byte store: single-port synchronous memory with erase sweep after reset.
module ssbm_mem #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssbm_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata,
    output logic              o_busy
);
    import ssbm_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);

    logic [7:0]    r_mem [MEM_DEPTH];
    logic [7:0]    r_rdata;
    logic          r_clearing;
    logic [AW-1:0] r_clr_idx;

    // erase sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(MEM_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= ERASED;
        end else if (i_req.wr_en) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

### rtl/ssbm_ctrl.sv
// Frame sequencer: command decode, address reduction, output register.
module ssbm_ctrl #(
    parameter int MEM_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_busy,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [7:0]         o_m_tdata,
    output logic               o_m_tuser,
    output logic               o_m_tlast,
    output ssbm_pkg::t_mem_req o_mem_req,
    input  logic [7:0]         i_mem_rdata
);
    import ssbm_pkg::*;

    localparam int          AW      = $clog2(MEM_DEPTH);
    localparam bit          IS_POW2 = (MEM_DEPTH == (1 << AW));
    // ceil(2^32 / depth): quotient is exact for every 16-bit address
    localparam logic [24:0] RECIP   =
        25'(((64'd1 << 32) + 64'(MEM_DEPTH) - 64'd1) / 64'(MEM_DEPTH));
    localparam logic [16:0] DEP17   = 17'(MEM_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_mode, n_mode;
    logic [15:0] r_rem, n_rem;
    logic [2:0]  r_step, n_step;
    logic [7:0]  r_quo, n_quo;
    logic [7:0]  r_read_val, n_read_val;
    logic        r_out_valid, n_out_valid;
    logic        r_out_load, n_out_load;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_out_last, n_out_last;

    logic        acc;
    logic        out_free;
    logic        is_read;
    logic [15:0] addr_full;
    logic [39:0] prod;
    logic [7:0]  quo_est;
    logic [24:0] quo_dep;
    logic [15:0] rem_red;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && !i_busy && out_free;
    assign acc        = i_s_tvalid && o_s_tready;
    assign is_read    = (r_mode == READ_MODE);
    assign addr_full  = {i_s_tdata, r_rem[7:0]};

    // address mod depth: reciprocal quotient registered first, remainder in the next cycle
    assign prod    = 40'(r_rem) * 40'(RECIP);
    assign quo_est = prod[39:32];
    assign quo_dep = 25'(r_quo) * 25'(DEP17);
    assign rem_red = r_rem - quo_dep[15:0];

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_mode      = r_mode;
        n_rem       = r_rem;
        n_step      = r_step;
        n_quo       = r_quo;
        n_read_val  = r_read_val;
        n_out_valid = r_out_valid;
        n_out_load  = r_out_load;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_mem_req   = '0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    // default result: nothing loaded, frame open
                    n_out_valid = 1'b1;
                    n_out_load  = 1'b0;
                    n_out_byte  = 8'd0;
                    n_out_last  = 1'b0;
                    unique case (r_phase)
                        PH_ADDR_LO: begin
                            n_rem   = {8'd0, i_s_tdata};
                            n_phase = PH_ADDR_HI;
                        end
                        PH_ADDR_HI: begin
                            n_rem   = addr_full;
                            n_step  = 3'd1;
                            n_phase = PH_FINAL;
                            if (is_read) begin
                                n_out_valid = 1'b0;
                            end
                            if (IS_POW2) begin
                                if (is_read) begin
                                    o_mem_req.rd_en = 1'b1;
                                    o_mem_req.addr  = addr_full;
                                    n_state         = ST_READ;
                                end
                            end else begin
                                n_state = ST_MOD;
                            end
                        end
                        PH_FINAL: begin
                            if (is_read) begin
                                n_out_load = 1'b1;
                                n_out_byte = r_read_val;
                            end else begin
                                o_mem_req.wr_en = 1'b1;
                                o_mem_req.addr  = r_rem;
                                o_mem_req.wdata = i_s_tdata;
                            end
                            n_out_last = 1'b1;
                            n_phase    = PH_MODE;
                            n_mode     = 8'd0;
                            n_rem      = 16'd0;
                        end
                        default: begin
                            n_mode  = i_s_tdata;
                            n_phase = PH_ADDR_LO;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                n_step = r_step - 3'd1;
                if (r_step != 3'd0) begin
                    n_quo = quo_est;
                end else begin
                    n_rem = rem_red;
                    if (is_read) begin
                        o_mem_req.rd_en = 1'b1;
                        o_mem_req.addr  = rem_red;
                        n_state         = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_load  = 1'b1;
                    n_out_byte  = i_mem_rdata;
                    n_out_last  = 1'b0;
                    n_read_val  = i_mem_rdata;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_MODE;
            r_mode      <= 8'd0;
            r_rem       <= 16'd0;
            r_step      <= 3'd0;
            r_quo       <= 8'd0;
            r_read_val  <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_mode      <= n_mode;
            r_rem       <= n_rem;
            r_step      <= n_step;
            r_quo       <= n_quo;
            r_read_val  <= n_read_val;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_load <= n_out_load;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = r_out_load;
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/spi_slave_byte_memory_unit.sv
// Top level of the SPI slave byte memory: sequencer plus byte store.
// Each accepted byte yields a registered result; for a read address-high byte
//   it comes from the memory read, after modulo reduction for non-power-of-two
//   depths. Throughput: 1 item/cycle; input waits after a read address until the
//   read data is loaded, and for other depths during every reduction; a stalled
//   result holds it. Reset: sync, active low; an erase pass then writes 0xFF to
//   all MEM_DEPTH entries, one per cycle, and no item is accepted until it is done.
module spi_slave_byte_memory_unit #(
    parameter int MEM_DEPTH = 1024   // 256 .. 65536 entries
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // received byte stream
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    // transmit-load result stream
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] tx_byte (0 unless tx_load)
    output logic       o_m_axis_tuser,   // [0] tx_load
    output logic       o_m_axis_tlast    // frame_done
);
    import ssbm_pkg::*;

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic       mem_busy;

    // frame decode, address reduction and output register
    ssbm_ctrl #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_busy      (mem_busy),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .o_m_tlast   (o_m_axis_tlast),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // byte store, one access per cycle, read data registered
    ssbm_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

endmodule

### rtl/ssbm_checker.sv
// Port-level checks for the SPI slave byte memory, bound to the top level.
module ssbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // no transmit byte unless one is loaded
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == 8'd0)
        else $error("tx byte nonzero without load");

    // erase pass keeps input off right after reset
    a_erase: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("input accepted during erase");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind spi_slave_byte_memory_unit ssbm_checker u_ssbm_checker (.*);
